/* hdl/cca_pkg.sv */
// ----------------------------------------------------------------------------
// cca_pkg - shared definitions for the calendar clock with alarm
// Field widths, reset values, wrap limits and configuration indexes.
// ----------------------------------------------------------------------------
package cca_pkg;

  // field widths
  localparam int TICK_W    = 10;
  localparam int SEC_W     = 6;
  localparam int MIN_W     = 6;
  localparam int HOUR_W    = 5;
  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 14;
  localparam int WDAY_W    = 3;
  localparam int CHIME_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;
  localparam int IN_BYTES_W  = 8;
  localparam int OUT_BYTES_W = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOUR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MINUTE = 2'd2;

  // reset values
  localparam logic [TICK_W-1:0]  TICK_LIMIT_RST = 10'd100;
  localparam logic [YEAR_W-1:0]  YEAR_RST       = 14'd2000;
  localparam logic [CHIME_W-1:0] CHIME_RST      = 3'd5;
  localparam logic [CHIME_W-1:0] CHIME_RELOAD   = 3'd4;

  // wrap limits
  localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;
  localparam logic [MIN_W-1:0]   MIN_LAST   = 6'd59;
  localparam logic [HOUR_W-1:0]  HOUR_LAST  = 5'd23;
  localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_LAST  = 14'd9999;
  localparam logic [WDAY_W-1:0]  WDAY_LAST  = 3'd6;

  // time and date of the calendar
  typedef struct packed {
    logic [SEC_W-1:0]   sec;
    logic [MIN_W-1:0]   min;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [WDAY_W-1:0]  wday;
  } cca_time_t;

endpackage

/* hdl/calendar_clock_with_alarm.sv */
// ----------------------------------------------------------------------------
// calendar_clock_with_alarm - tick driven calendar clock with alarm and chime
// Prescaler, second to year carry chain, alarm latch and hourly chime.
// ----------------------------------------------------------------------------
// Usage:
//   Each in_ beat is one timer tick and carries the current month length and
//   an alarm stop flag. Each tick gives exactly one out_ beat with the time,
//   date, weekday, a second strobe, the alarm state and the buzzer level,
//   all taken after the tick was handled.
//   The cfg_ port writes tick_limit, alarm_hour and alarm_minute; write it
//   only while no tick is in flight.
// Pipeline and throughput:
//   a tick is registered at the input, then the carry chain and alarm logic
//   update the calendar registers and the output register together; one
//   tick per cycle sustained while out_tready stays high.
// Reset:
//   synchronous, active low; the calendar returns to 2000-01-01 00:00:00,
//   alarm and chime clear, tick_limit returns to 100.
// Stall:
//   when out_tready is low the result beat holds; one more tick is held in
//   the input register, after that in_tready drops.
// ----------------------------------------------------------------------------
module calendar_clock_with_alarm (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [cca_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [cca_pkg::CFG_DAT_W-1:0] cfg_wdata,
  // tick input
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [4:0] days_in_month, [5] stop_alarm, [7:6] zero
  input  logic [cca_pkg::IN_BYTES_W-1:0] in_tdata,
  // result output
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [5:0] second_now, [11:6] minute_now, [16:12] hour_now, [21:17] day_now,
  // [25:22] month_now, [39:26] year_now, [42:40] weekday_now,
  // [43] second_strobe, [44] alarm_on, [45] buzzer_on, [47:46] zero
  output logic [cca_pkg::OUT_BYTES_W-1:0] out_tdata
);
  import cca_pkg::*;

  // configuration registers
  logic [TICK_W-1:0]  tick_limit_r;
  logic [HOUR_W-1:0]  alarm_hour_r;
  logic [MIN_W-1:0]   alarm_minute_r;

  // input stage
  logic               s1_valid_r;
  logic [DAY_W-1:0]   s1_dim_r;
  logic               s1_stop_r;

  // calendar state
  cca_time_t          time_r, time_nxt;
  logic [TICK_W-1:0]  tick_count_r, tick_count_nxt;
  logic               alarm_r, alarm_nxt;
  logic               chime_act_r, chime_act_nxt;
  logic [CHIME_W-1:0] chime_steps_r, chime_steps_nxt;
  logic               buzzer_r, buzzer_nxt;
  logic               strobe_nxt;

  // output stage
  logic                   out_valid_r;
  logic [OUT_BYTES_W-1:0] out_data_r, out_data_nxt;

  logic out_adv;
  logic s1_fire;
  logic alarm_kept;
  logic chime_on;
  logic alarm_match;

  assign out_adv    = !out_valid_r || out_tready;
  assign s1_fire    = s1_valid_r && out_adv;
  assign in_tready  = !s1_valid_r || out_adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // prescaler, carry chain, alarm and chime for one tick
  always_comb begin
    time_nxt        = time_r;
    tick_count_nxt  = tick_count_r;
    chime_act_nxt   = chime_act_r;
    chime_steps_nxt = chime_steps_r;
    buzzer_nxt      = buzzer_r;
    strobe_nxt      = 1'b0;
    alarm_kept      = alarm_r && !s1_stop_r;
    alarm_nxt       = alarm_kept;
    chime_on        = chime_act_r;
    alarm_match     = 1'b0;

    if (tick_count_r < tick_limit_r) begin
      tick_count_nxt = tick_count_r + 10'd1;
    end else begin
      tick_count_nxt = '0;
      strobe_nxt     = 1'b1;

      // carry chain from seconds up to the year
      if (time_r.sec < SEC_LAST) begin
        time_nxt.sec = time_r.sec + 6'd1;
      end else begin
        time_nxt.sec = '0;
        if (time_r.min < MIN_LAST) begin
          time_nxt.min = time_r.min + 6'd1;
        end else begin
          time_nxt.min = '0;
          if (time_r.hour < HOUR_LAST) begin
            time_nxt.hour = time_r.hour + 5'd1;
          end else begin
            time_nxt.hour = '0;
            time_nxt.wday = (time_r.wday >= WDAY_LAST) ? '0 : time_r.wday + 3'd1;
            if (time_r.day < s1_dim_r) begin
              time_nxt.day = time_r.day + 5'd1;
            end else begin
              time_nxt.day = 5'd1;
              if (time_r.month < MONTH_LAST) begin
                time_nxt.month = time_r.month + 4'd1;
              end else begin
                time_nxt.month = 4'd1;
                time_nxt.year  = (time_r.year >= YEAR_LAST) ? '0
                                                            : time_r.year + 14'd1;
              end
            end
          end
        end
      end

      // full hour starts the chime
      chime_on = chime_act_r || (time_nxt.sec == '0 && time_nxt.min == '0);

      // alarm latches at second zero of the set hour and minute
      alarm_match = (time_nxt.sec == '0) && (time_nxt.hour == alarm_hour_r) &&
                    (time_nxt.min == alarm_minute_r);
      alarm_nxt   = alarm_kept || alarm_match;

      // buzzer follows the alarm unless the chime drives it
      buzzer_nxt    = alarm_nxt;
      chime_act_nxt = chime_on;
      if (chime_on) begin
        if (chime_steps_r == '0) begin
          chime_act_nxt   = 1'b0;
          chime_steps_nxt = CHIME_RELOAD;
        end else begin
          buzzer_nxt      = !chime_steps_r[0];
          chime_steps_nxt = chime_steps_r - 3'd1;
        end
      end
    end

    out_data_nxt = {2'b00, buzzer_nxt, alarm_nxt, strobe_nxt, time_nxt.wday,
                    time_nxt.year, time_nxt.month, time_nxt.day, time_nxt.hour,
                    time_nxt.min, time_nxt.sec};
  end

  // control, configuration and calendar state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_limit_r   <= TICK_LIMIT_RST;
      alarm_hour_r   <= '0;
      alarm_minute_r <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      tick_count_r   <= '0;
      time_r.sec     <= '0;
      time_r.min     <= '0;
      time_r.hour    <= '0;
      time_r.day     <= 5'd1;
      time_r.month   <= 4'd1;
      time_r.year    <= YEAR_RST;
      time_r.wday    <= '0;
      alarm_r        <= 1'b0;
      chime_act_r    <= 1'b0;
      chime_steps_r  <= CHIME_RST;
      buzzer_r       <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TICK_LIMIT:   tick_limit_r   <= cfg_wdata;
          CFG_ALARM_HOUR:   alarm_hour_r   <= cfg_wdata[HOUR_W-1:0];
          CFG_ALARM_MINUTE: alarm_minute_r <= cfg_wdata[MIN_W-1:0];
          default: ;
        endcase
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        tick_count_r  <= tick_count_nxt;
        time_r        <= time_nxt;
        alarm_r       <= alarm_nxt;
        chime_act_r   <= chime_act_nxt;
        chime_steps_r <= chime_steps_nxt;
        buzzer_r      <= buzzer_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_dim_r  <= in_tdata[DAY_W-1:0];
      s1_stop_r <= in_tdata[DAY_W];
    end
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* hdl/cca_checker.sv */
// ----------------------------------------------------------------------------
// cca_checker - port level checks for the calendar clock with alarm
// Watches the result beats and the handshake of the top level.
// ----------------------------------------------------------------------------
module cca_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cca_pkg::OUT_BYTES_W-1:0] out_tdata
);
  import cca_pkg::*;

  logic prev_valid_r;
  logic prev_alarm_r;
  logic prev_buzzer_r;
  logic out_beat;
  logic beat_strobe;

  assign out_beat    = out_tvalid && out_tready;
  assign beat_strobe = out_tdata[43];

  // remember the previous result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r <= 1'b0;
    end else if (out_beat) begin
      prev_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      prev_alarm_r  <= out_tdata[44];
      prev_buzzer_r <= out_tdata[45];
    end
  end

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // with the output register empty a tick is always taken
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // time of day stays in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:0] <= SEC_LAST) && (out_tdata[11:6] <= MIN_LAST) &&
                   (out_tdata[16:12] <= HOUR_LAST))
    else $error("time field out of range");

  // buzzer only changes on a second
  a_buzzer_on_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && prev_valid_r && !beat_strobe |-> out_tdata[45] == prev_buzzer_r)
    else $error("buzzer changed between seconds");

  // alarm only rises on a second
  a_alarm_on_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && prev_valid_r && out_tdata[44] && !prev_alarm_r |-> beat_strobe)
    else $error("alarm rose between seconds");

endmodule

bind calendar_clock_with_alarm cca_checker u_cca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the calendar clock with alarm
// Drives timer ticks on the in_ stream and predicts every out_ beat: the
// prescaler, the carry chain up to the year, the alarm latch and the hourly
// chime. A short directed table is followed by random blocks under several
// idle patterns, then a run at one second per tick through each idle pattern.
// ----------------------------------------------------------------------------
module testbench;
  import cca_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int MAX_REPORTS = 10;

  // idle patterns on the two streams
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // one result beat, packed as on out_tdata, second_now in the lowest bits
  typedef struct packed {
    logic               buzzer;
    logic               alarm;
    logic               strobe;
    logic [WDAY_W-1:0]  wday;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   sec;
  } clock_beat_t;

  // one row of the directed table
  typedef struct {
    bit                   wr;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] val;
    logic [DAY_W-1:0]     dim;
    logic                 stop;
    bit                   typed;
    clock_beat_t          want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_BYTES_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_BYTES_W-1:0] out_tdata;

  // predicted configuration
  logic [TICK_W-1:0] lim_reg;
  logic [HOUR_W-1:0] alm_hour;
  logic [MIN_W-1:0]  alm_min;

  // predicted calendar state
  logic [TICK_W-1:0]  pre_cnt;
  logic [SEC_W-1:0]   t_sec;
  logic [MIN_W-1:0]   t_min;
  logic [HOUR_W-1:0]  t_hour;
  logic [DAY_W-1:0]   t_day;
  logic [MONTH_W-1:0] t_month;
  logic [YEAR_W-1:0]  t_year;
  logic [WDAY_W-1:0]  t_wday;
  logic               alarm_set;
  logic               chime_run;
  logic [CHIME_W-1:0] chime_left;
  logic               buzz;

  clock_beat_t expected_times[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int bad_beats = 0;
  int checked_beats = 0;
  int n_ticks = 0;
  int n_seconds = 0;
  int n_alarms = 0;
  int n_chimes = 0;
  int n_midnights = 0;

  dir_row_t dir_tab[17];

  calendar_clock_with_alarm DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycles,
               expected_times.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    clock_beat_t got;
    clock_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(clock_beat_t)-1:0];
      if (expected_times.size() == 0) begin
        bad_beats <= bad_beats + 1;
        if (bad_beats < MAX_REPORTS)
          $display("%0t: result beat with nothing expected: %h", $realtime, out_tdata);
      end else begin
        want = expected_times.pop_front();
        checked_beats <= checked_beats + 1;
        if (got !== want || out_tdata[OUT_BYTES_W-1:$bits(clock_beat_t)] !== '0) begin
          bad_beats <= bad_beats + 1;
          if (bad_beats < MAX_REPORTS) begin
            $display("%0t: mismatch on beat %0d (pad %b)", $realtime, checked_beats,
                     out_tdata[OUT_BYTES_W-1:$bits(clock_beat_t)]);
            $display("  want %0d:%0d:%0d %0d-%0d-%0d wd %0d strobe %b alarm %b buzz %b",
                     want.hour, want.minute, want.sec, want.year, want.month, want.day,
                     want.wday, want.strobe, want.alarm, want.buzzer);
            $display("  got  %0d:%0d:%0d %0d-%0d-%0d wd %0d strobe %b alarm %b buzz %b",
                     got.hour, got.minute, got.sec, got.year, got.month, got.day,
                     got.wday, got.strobe, got.alarm, got.buzzer);
          end
        end
      end
    end
  end

  function automatic clock_beat_t beat_of(int s, int m, int h, int d, int mo, int y,
                                          int w, int st, int al, int bz);
    clock_beat_t b;
    b.sec = SEC_W'(s);
    b.minute = MIN_W'(m);
    b.hour = HOUR_W'(h);
    b.day = DAY_W'(d);
    b.month = MONTH_W'(mo);
    b.year = YEAR_W'(y);
    b.wday = WDAY_W'(w);
    b.strobe = 1'(st);
    b.alarm = 1'(al);
    b.buzzer = 1'(bz);
    return b;
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      IDLE_SEND: begin
        gap_pct = 45;
        stall_pct = 0;
      end
      IDLE_RECV: begin
        gap_pct = 0;
        stall_pct = 45;
      end
      default: begin
        gap_pct = 33;
        stall_pct = 33;
      end
    endcase
  endtask

  // hold the input until every expected beat has arrived
  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_times.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TICK_LIMIT:   lim_reg = val[TICK_W-1:0];
      CFG_ALARM_HOUR:   alm_hour = val[HOUR_W-1:0];
      CFG_ALARM_MINUTE: alm_min = val[MIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // send one tick beat and predict the calendar after it
  task automatic drive_tick(input logic [DAY_W-1:0] dim, input logic stop,
                            input bit typed, input clock_beat_t typed_want);
    logic fire;
    clock_beat_t b;
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, stop, dim};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_ticks++;

    // stop flag clears the latch first
    fire = 1'b0;
    if (stop) alarm_set = 1'b0;
    if (pre_cnt < lim_reg) begin
      pre_cnt = pre_cnt + 10'd1;
    end else begin
      pre_cnt = '0;
      fire = 1'b1;
      n_seconds++;
      // carry chain
      if (t_sec < SEC_LAST) begin
        t_sec = t_sec + 6'd1;
      end else begin
        t_sec = '0;
        if (t_min < MIN_LAST) begin
          t_min = t_min + 6'd1;
        end else begin
          t_min = '0;
          if (t_hour < HOUR_LAST) begin
            t_hour = t_hour + 5'd1;
          end else begin
            t_hour = '0;
            n_midnights++;
            t_wday = (t_wday >= WDAY_LAST) ? '0 : t_wday + 3'd1;
            if (t_day < dim) begin
              t_day = t_day + 5'd1;
            end else begin
              t_day = 5'd1;
              if (t_month < MONTH_LAST) begin
                t_month = t_month + 4'd1;
              end else begin
                t_month = 4'd1;
                t_year = (t_year >= YEAR_LAST) ? '0 : t_year + 14'd1;
              end
            end
          end
        end
      end
      // full hour starts the chime, a running chime keeps its count
      if (t_sec == 0 && t_min == 0) begin
        chime_run = 1'b1;
        n_chimes++;
      end
      if (!alarm_set && t_sec == 0 && t_hour == alm_hour && t_min == alm_min) begin
        alarm_set = 1'b1;
        n_alarms++;
      end
      // buzzer follows the alarm unless the chime overrides it
      buzz = alarm_set;
      if (chime_run) begin
        if (chime_left == 0) begin
          chime_run = 1'b0;
          chime_left = CHIME_RELOAD;
        end else begin
          buzz = ~chime_left[0];
          chime_left = chime_left - 3'd1;
        end
      end
    end

    b.sec = t_sec;
    b.minute = t_min;
    b.hour = t_hour;
    b.day = t_day;
    b.month = t_month;
    b.year = t_year;
    b.wday = t_wday;
    b.strobe = fire;
    b.alarm = alarm_set;
    b.buzzer = buzz;
    expected_times.push_back(typed ? typed_want : b);
    @(negedge clk);
  endtask

  initial begin
    int lim;
    int ah;
    int am;
    int n;
    logic [DAY_W-1:0] dim;

    // power-up state
    lim_reg = TICK_LIMIT_RST;
    alm_hour = '0;
    alm_min = '0;
    pre_cnt = '0;
    t_sec = '0;
    t_min = '0;
    t_hour = '0;
    t_day = 5'd1;
    t_month = 4'd1;
    t_year = YEAR_RST;
    t_wday = '0;
    alarm_set = 1'b0;
    chime_run = 1'b0;
    chime_left = CHIME_RST;
    buzz = 1'b0;

    // directed table: reset state, limit extremes, count above limit,
    // unreachable alarm, month length extremes, stop flag
    dir_tab[0]  = '{1'b0, CFG_TICK_LIMIT, 10'd0, 5'd31, 1'b0, 1'b1,
                    beat_of(0, 0, 0, 1, 1, 2000, 0, 0, 0, 0)};
    dir_tab[1]  = '{1'b0, CFG_TICK_LIMIT, 10'd0, 5'd0, 1'b1, 1'b1,
                    beat_of(0, 0, 0, 1, 1, 2000, 0, 0, 0, 0)};
    dir_tab[2]  = '{1'b1, CFG_TICK_LIMIT, 10'd0, 5'd28, 1'b0, 1'b1,
                    beat_of(1, 0, 0, 1, 1, 2000, 0, 1, 0, 0)};
    dir_tab[3]  = '{1'b0, CFG_TICK_LIMIT, 10'd0, 5'd31, 1'b1, 1'b1,
                    beat_of(2, 0, 0, 1, 1, 2000, 0, 1, 0, 0)};
    dir_tab[4]  = '{1'b1, CFG_ALARM_HOUR, 10'd31, 5'd30, 1'b0, 1'b0, '0};
    dir_tab[5]  = '{1'b1, CFG_ALARM_MINUTE, 10'd63, 5'd29, 1'b1, 1'b0, '0};
    dir_tab[6]  = '{1'b1, CFG_TICK_LIMIT, 10'd1023, 5'd31, 1'b0, 1'b1,
                    beat_of(4, 0, 0, 1, 1, 2000, 0, 0, 0, 0)};
    dir_tab[7]  = '{1'b0, CFG_TICK_LIMIT, 10'd0, 5'd0, 1'b0, 1'b0, '0};
    dir_tab[8]  = '{1'b0, CFG_TICK_LIMIT, 10'd0, 5'd1, 1'b1, 1'b0, '0};
    dir_tab[9]  = '{1'b0, CFG_TICK_LIMIT, 10'd0, 5'd17, 1'b0, 1'b0, '0};
    dir_tab[10] = '{1'b1, CFG_TICK_LIMIT, 10'd1, 5'd14, 1'b0, 1'b0, '0};
    dir_tab[11] = '{1'b0, CFG_TICK_LIMIT, 10'd0, 5'd21, 1'b1, 1'b0, '0};
    dir_tab[12] = '{1'b0, CFG_TICK_LIMIT, 10'd0, 5'd10, 1'b0, 1'b0, '0};
    dir_tab[13] = '{1'b1, CFG_ALARM_HOUR, 10'd0, 5'd31, 1'b0, 1'b0, '0};
    dir_tab[14] = '{1'b1, CFG_ALARM_MINUTE, 10'd1, 5'd28, 1'b0, 1'b0, '0};
    dir_tab[15] = '{1'b1, CFG_TICK_LIMIT, 10'd0, 5'd31, 1'b0, 1'b0, '0};
    dir_tab[16] = '{1'b0, CFG_TICK_LIMIT, 10'd0, 5'd31, 1'b1, 1'b0, '0};

    // hold reset, then release it
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_idle(IDLE_NONE);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr) begin
        drain();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end
      drive_tick(dir_tab[i].dim, dir_tab[i].stop, dir_tab[i].typed, dir_tab[i].want);
    end

    // random blocks, each with a fresh limit and an alarm due soon
    for (int ph = 0; ph < 4; ph++) begin
      set_idle(idle_mode_t'(ph));
      for (int blk = 0; blk < 5; blk++) begin
        drain();
        n = $urandom_range(0, 9);
        if (n < 6) lim = $urandom_range(0, 3);
        else if (n < 9) lim = $urandom_range(4, 15);
        else lim = 1023;
        write_reg(CFG_TICK_LIMIT, CFG_DAT_W'(lim));
        ah = int'(t_hour);
        am = int'(t_min) + 1;
        if (am > MIN_LAST) begin
          am = 0;
          ah = (ah >= HOUR_LAST) ? 0 : ah + 1;
        end
        // now and then an alarm time that can never match
        n = $urandom_range(0, 7);
        if (n == 0) ah = $urandom_range(24, 31);
        else if (n == 1) am = $urandom_range(60, 63);
        write_reg(CFG_ALARM_HOUR, CFG_DAT_W'(ah));
        write_reg(CFG_ALARM_MINUTE, CFG_DAT_W'(am));
        repeat (50) drive_tick(DAY_W'($urandom_range(0, 31)),
                               ($urandom_range(0, 29) == 0), 1'b0, '0);
      end
    end

    // one second per tick, stepping through every idle pattern
    drain();
    write_reg(CFG_TICK_LIMIT, '0);
    write_reg(CFG_ALARM_HOUR, CFG_DAT_W'($urandom_range(0, 23)));
    write_reg(CFG_ALARM_MINUTE, CFG_DAT_W'($urandom_range(0, 59)));
    for (n = 0; n < 100; n++) begin
      if (n % 25 == 0) set_idle(idle_mode_t'(n / 25));
      dim = DAY_W'($urandom_range(0, 31));
      drive_tick(dim, ($urandom_range(0, 299) == 0), 1'b0, '0);
    end

    drain();
    repeat (10) @(negedge clk);
    $display("summary: %0d ticks, %0d beats checked, %0d seconds, %0d midnights",
             n_ticks, checked_beats, n_seconds, n_midnights);
    $display("summary: %0d alarm latches, %0d hourly chimes, %0d mismatches",
             n_alarms, n_chimes, bad_beats);
    if (bad_beats == 0 && expected_times.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
